// ===== rtl/gst_pkg.sv =====
// Shared types, codes and defaults for the generational slot table.
package gst_pkg;

  localparam int SLOTS_DEF    = 256;
  localparam int GEN_BITS_DEF = 16;

  localparam logic [2:0] KIND_ALLOC    = 3'd0;
  localparam logic [2:0] KIND_MARK     = 3'd1;
  localparam logic [2:0] KIND_SWEEP    = 3'd2;
  localparam logic [2:0] KIND_VALIDATE = 3'd3;
  localparam logic [2:0] KIND_CLEAR    = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  slot_index;
    logic [15:0] handle_generation;
  } gst_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        handle_valid;
    logic [7:0]  given_index;
    logic [15:0] given_generation;
    logic [8:0]  released_count;
  } gst_out_t;

  typedef struct packed {
    logic load;
    logic rd_slot_idx;
    logic rd_stack;
    logic rd_slot_pop;
    logic sweep_start;
    logic sweep_step;
    logic finish;
  } gst_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_sweep;
    logic needs_read;
    logic have_free;
    logic sweep_done;
    logic out_free;
  } gst_sts_t;

endpackage

// ===== rtl/generational_slot_table.sv =====
// Generational slot table: handle allocate, mark, sweep, validate and clear.
// Steps per item: mark and validate read the slot; an allocate that pops the free stack
// reads the stack, then the popped slot; a sweep reads every slot below high_water.
// One item in flight; the next is taken the cycle after its result is registered,
// and the result waits while a held output is stalled.
// Reset empties the table by clearing high_water and free_count; no memory pass.
module generational_slot_table #(
  parameter int SLOTS    = gst_pkg::SLOTS_DEF,
  parameter int GEN_BITS = gst_pkg::GEN_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gst_pkg::gst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gst_pkg::gst_out_t out_data
);
  import gst_pkg::*;

  gst_cmd_t cmd;
  gst_sts_t sts;

  gst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gst_datapath #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== rtl/gst_ctrl.sv =====
// Sequencing state machine for the generational slot table.
module gst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gst_pkg::gst_sts_t sts,
  output gst_pkg::gst_cmd_t cmd
);
  import gst_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_POP   = 5'b00100,
    S_SWEEP = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (sts.is_alloc && sts.have_free) begin
          cmd.rd_stack = 1'b1;
          state_nxt    = S_POP;
        end else if (sts.needs_read) begin
          cmd.rd_slot_idx = 1'b1;
          state_nxt       = S_DONE;
        end else if (sts.is_sweep) begin
          cmd.sweep_start = 1'b1;
          state_nxt       = S_SWEEP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        // stack data has landed: fetch the popped slot's generation
        cmd.rd_slot_pop = 1'b1;
        state_nxt       = S_DONE;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/gst_datapath.sv =====
// Slot and free-stack memories, counters and result register.
module gst_datapath #(
  parameter int SLOTS    = gst_pkg::SLOTS_DEF,
  parameter int GEN_BITS = gst_pkg::GEN_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gst_pkg::gst_in_t  in_data,
  input  logic              out_stall,
  output logic              out_valid,
  output gst_pkg::gst_out_t out_data,
  input  gst_pkg::gst_cmd_t cmd,
  output gst_pkg::gst_sts_t sts
);
  import gst_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = CNT_W + 8;
  localparam logic [31:0] GEN_MASK = 32'((64'd1 << GEN_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  typedef struct packed {
    logic                occ;
    logic                pend;
    logic [GEN_BITS-1:0] gen;
  } slot_t;

  slot_t            slot_mem [SLOTS];
  logic [IDX_W-1:0] stack_mem [SLOTS];

  gst_in_t          item_r;
  logic [CNT_W-1:0] hw_r, hw_nxt;
  logic [CNT_W-1:0] fc_r, fc_nxt;
  logic             pop_path_r, pop_path_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             chk_r, chk_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0] rel_r, rel_nxt;
  logic             out_valid_r;
  gst_out_t         out_data_r;
  gst_out_t         res;
  slot_t            slot_q_r;
  logic [IDX_W-1:0] stack_q_r;

  logic             slot_we, slot_re;
  logic [IDX_W-1:0] slot_wa, slot_ra;
  slot_t            slot_wd;
  logic             stk_we, stk_re;
  logic [IDX_W-1:0] stk_wa, stk_ra;

  logic             in_range;
  logic             gen_match;
  logic [IDX_W-1:0] idx_addr;

  assign idx_addr  = IDX_W'(item_r.slot_index);
  assign in_range  = CMP_W'(item_r.slot_index) < CMP_W'(hw_r);
  assign gen_match = (32'(slot_q_r.gen) ==
                      (32'(item_r.handle_generation) & GEN_MASK));

  assign sts.is_alloc   = (item_r.kind == KIND_ALLOC);
  assign sts.is_sweep   = (item_r.kind == KIND_SWEEP);
  assign sts.needs_read = (item_r.kind == KIND_MARK) || (item_r.kind == KIND_VALIDATE);
  assign sts.have_free  = (fc_r != '0);
  assign sts.sweep_done = (ptr_r == hw_r) && !chk_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    hw_nxt       = hw_r;
    fc_nxt       = fc_r;
    pop_path_nxt = pop_path_r;
    ptr_nxt      = ptr_r;
    chk_nxt      = chk_r;
    chk_idx_nxt  = chk_idx_r;
    rel_nxt      = rel_r;
    slot_we      = 1'b0;
    slot_wa      = '0;
    slot_wd      = '0;
    slot_re      = 1'b0;
    slot_ra      = '0;
    stk_we       = 1'b0;
    stk_wa       = '0;
    stk_re       = 1'b0;
    stk_ra       = '0;
    res          = '0;

    if (cmd.load) begin
      pop_path_nxt = 1'b0;
    end

    if (cmd.rd_slot_idx) begin
      slot_re = 1'b1;
      slot_ra = idx_addr;
    end

    if (cmd.rd_stack) begin
      stk_re       = 1'b1;
      stk_ra       = IDX_W'(fc_r - 1'b1);
      fc_nxt       = fc_r - 1'b1;
      pop_path_nxt = 1'b1;
    end

    if (cmd.rd_slot_pop) begin
      slot_re = 1'b1;
      slot_ra = stack_q_r;
    end

    if (cmd.sweep_start) begin
      ptr_nxt = '0;
      chk_nxt = 1'b0;
      rel_nxt = '0;
    end

    // sweep: read slot ptr while retiring the slot read in the previous step
    if (cmd.sweep_step) begin
      if (ptr_r < hw_r) begin
        slot_re     = 1'b1;
        slot_ra     = IDX_W'(ptr_r);
        chk_nxt     = 1'b1;
        chk_idx_nxt = IDX_W'(ptr_r);
        ptr_nxt     = ptr_r + 1'b1;
      end else begin
        chk_nxt = 1'b0;
      end
      if (chk_r && slot_q_r.occ && slot_q_r.pend) begin
        slot_we      = 1'b1;
        slot_wa      = chk_idx_r;
        slot_wd.occ  = 1'b0;
        slot_wd.pend = 1'b0;
        slot_wd.gen  = slot_q_r.gen + 1'b1;
        if (fc_r < SLOTS_CNT) begin
          stk_we = 1'b1;
          stk_wa = IDX_W'(fc_r);
          fc_nxt = fc_r + 1'b1;
        end
        rel_nxt = rel_r + 1'b1;
      end
    end

    if (cmd.finish) begin
      case (item_r.kind)
        KIND_ALLOC: begin
          if (pop_path_r) begin
            slot_we              = 1'b1;
            slot_wa              = stack_q_r;
            slot_wd.occ          = 1'b1;
            slot_wd.pend         = 1'b0;
            slot_wd.gen          = slot_q_r.gen;
            res.given_index      = 8'(stack_q_r);
            res.given_generation = 16'(slot_q_r.gen);
          end else if (hw_r < SLOTS_CNT) begin
            slot_we              = 1'b1;
            slot_wa              = IDX_W'(hw_r);
            slot_wd.occ          = 1'b1;
            slot_wd.pend         = 1'b0;
            slot_wd.gen          = '0;
            hw_nxt               = hw_r + 1'b1;
            res.given_index      = 8'(hw_r);
          end else begin
            res.status = ST_FULL;
          end
        end
        KIND_MARK: begin
          if (in_range && slot_q_r.occ) begin
            slot_we      = 1'b1;
            slot_wa      = idx_addr;
            slot_wd.occ  = 1'b1;
            slot_wd.pend = 1'b1;
            slot_wd.gen  = slot_q_r.gen;
          end else begin
            res.status = ST_INVALID;
          end
        end
        KIND_SWEEP: begin
          res.released_count = 9'(rel_r);
        end
        KIND_VALIDATE: begin
          if (in_range && slot_q_r.occ && !slot_q_r.pend && gen_match) begin
            res.handle_valid = 1'b1;
          end else begin
            res.status = ST_INVALID;
          end
        end
        KIND_CLEAR: begin
          hw_nxt = '0;
          fc_nxt = '0;
        end
        default: begin
          res.status = ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r        <= '0;
      fc_r        <= '0;
      pop_path_r  <= 1'b0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hw_r       <= hw_nxt;
      fc_r       <= fc_nxt;
      pop_path_r <= pop_path_nxt;
      chk_r      <= chk_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.finish) begin
      out_data_r <= res;
    end
    ptr_r     <= ptr_nxt;
    chk_idx_r <= chk_idx_nxt;
    rel_r     <= rel_nxt;
  end

  // slot table: one write, one read port, registered read
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (slot_re) begin
      slot_q_r <= slot_mem[slot_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= IDX_W'(chk_idx_r);
    end
    if (stk_re) begin
      stack_q_r <= stack_mem[stk_ra];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_free_below_hw: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= hw_r)
    else $error("free stack deeper than high-water mark");

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= SLOTS_CNT)
    else $error("high-water mark beyond table");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_stack |-> fc_r != '0)
    else $error("pop from empty free stack");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sweep_step && chk_r) |-> CNT_W'(chk_idx_r) < hw_r)
    else $error("sweep retiring slot above high-water mark");
`endif

endmodule
